// ----- hw/rtl/btn_click_pkg.sv -----
// ----------------------------------------------------------------------------
// btn_click_pkg
// Shared types and constants for the button click detector: phase codes,
// click event codes, register indexes and register reset values.
// ----------------------------------------------------------------------------
package btn_click_pkg;

  // detector phases
  typedef enum logic [2:0] {
    PH_IDLE     = 3'd0,
    PH_DOWN     = 3'd1,
    PH_UP       = 3'd2,
    PH_COUNT    = 3'd3,
    PH_PRESS    = 3'd4,
    PH_PRESSEND = 3'd5
  } phase_t;

  // reported click events
  typedef enum logic [1:0] {
    EV_NONE   = 2'd0,
    EV_SINGLE = 2'd1,
    EV_DOUBLE = 2'd2
  } click_event_t;

  // register indexes on the config port
  typedef enum logic [1:0] {
    REG_DEBOUNCE   = 2'd0,
    REG_LONG_PRESS = 2'd1,
    REG_CLICK_GAP  = 2'd2
  } reg_index_t;

  localparam int unsigned CFG_W    = 16;
  localparam int unsigned COUNT_W  = 4;
  localparam int unsigned PADDR_W  = 4;
  localparam int unsigned PDATA_W  = 32;

  localparam logic [CFG_W-1:0] DEBOUNCE_RST   = 16'd50;
  localparam logic [CFG_W-1:0] LONG_PRESS_RST = 16'd800;
  localparam logic [CFG_W-1:0] CLICK_GAP_RST  = 16'd400;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  // one result beat
  typedef struct packed {
    click_event_t click_event;
    logic         held;
  } result_t;

endpackage

// ----- hw/rtl/button_click_detector_unit.sv -----
// ----------------------------------------------------------------------------
// button_click_detector_unit
// Debounces a sampled button level, counts clicks and reports single and
// double clicks after the click gap; flags the long-press phase.
// ----------------------------------------------------------------------------
// A result beat is registered into the result register, or into the skid
// register while one result waits. Throughput: one tick per cycle unless
// in_stall is high; the phase update is a single pass of compare logic from
// the state registers into the result register. The two-entry output stage
// (result plus skid register) keeps the input side moving while one waits.
// Reset (rst_n low, synchronous): phase idle, timer and click count zero,
// registers back to their defaults, output stage empty.
module button_click_detector_unit
  import btn_click_pkg::*;
#(
  parameter int unsigned TIMER_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  // input channel
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_pressed,
  // result channel
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         out_click_event,
  output logic               out_held,
  // config port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  localparam int unsigned CMP_W = (TIMER_BITS > CFG_W) ? TIMER_BITS : CFG_W;

  // config registers
  logic [CFG_W-1:0] debounce_r;
  logic [CFG_W-1:0] long_press_r;
  logic [CFG_W-1:0] click_gap_r;

  // detector state
  phase_t              phase_r,   phase_nxt;
  phase_t              prev_r,    prev_nxt;
  logic [TIMER_BITS-1:0] elapsed_r, elapsed_nxt;
  logic [COUNT_W-1:0]  count_r,   count_nxt;

  // output stage
  logic    out_valid_r;
  result_t out_data_r;
  logic    skid_valid_r;
  result_t skid_data_r;
  result_t result;

  logic                  in_beat;
  logic                  out_beat;
  logic                  cfg_wr;
  reg_index_t            cfg_idx;
  logic [TIMER_BITS-1:0] interval;
  logic [CMP_W-1:0]      interval_x;
  logic                  below_debounce;
  logic                  over_long_press;
  logic                  over_click_gap;

  assign pready   = 1'b1;
  assign cfg_idx  = reg_index_t'(paddr[3:2]);
  assign cfg_wr   = psel & penable & pwrite & pready;

  assign in_stall = skid_valid_r;
  assign in_beat  = in_valid & ~skid_valid_r;
  assign out_beat = out_valid_r & ~out_stall;

  // config writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_r   <= DEBOUNCE_RST;
      long_press_r <= LONG_PRESS_RST;
      click_gap_r  <= CLICK_GAP_RST;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_DEBOUNCE:   debounce_r   <= pwdata[CFG_W-1:0];
        REG_LONG_PRESS: long_press_r <= pwdata[CFG_W-1:0];
        REG_CLICK_GAP:  click_gap_r  <= pwdata[CFG_W-1:0];
        default: ;
      endcase
    end
  end

  // config readback
  always_comb begin
    unique case (cfg_idx)
      REG_DEBOUNCE:   prdata = PDATA_W'(debounce_r);
      REG_LONG_PRESS: prdata = PDATA_W'(long_press_r);
      REG_CLICK_GAP:  prdata = PDATA_W'(click_gap_r);
      default:        prdata = '0;
    endcase
  end

  // saturating tick interval and threshold compares
  assign interval        = (elapsed_r == '1) ? elapsed_r : elapsed_r + 1'b1;
  assign interval_x      = CMP_W'(interval);
  assign below_debounce  = interval_x < CMP_W'(debounce_r);
  assign over_long_press = interval_x > CMP_W'(long_press_r);
  assign over_click_gap  = interval_x > CMP_W'(click_gap_r);

  // next state
  always_comb begin
    phase_nxt   = phase_r;
    prev_nxt    = prev_r;
    elapsed_nxt = interval;
    count_nxt   = count_r;
    unique case (phase_r)
      PH_IDLE: begin
        if (in_pressed) begin
          prev_nxt    = phase_r;
          phase_nxt   = PH_DOWN;
          elapsed_nxt = '0;
          count_nxt   = '0;
        end
      end
      PH_DOWN: begin
        if (!in_pressed && below_debounce) begin
          prev_nxt  = phase_r;
          phase_nxt = prev_r;
        end else if (!in_pressed) begin
          prev_nxt    = phase_r;
          phase_nxt   = PH_UP;
          elapsed_nxt = '0;
        end else if (over_long_press) begin
          prev_nxt  = phase_r;
          phase_nxt = PH_PRESS;
        end
      end
      PH_UP: begin
        if (in_pressed && below_debounce) begin
          prev_nxt  = phase_r;
          phase_nxt = prev_r;
        end else if (!below_debounce) begin
          if (count_r != COUNT_MAX) count_nxt = count_r + 1'b1;
          prev_nxt  = phase_r;
          phase_nxt = PH_COUNT;
        end
      end
      PH_COUNT: begin
        if (in_pressed) begin
          prev_nxt    = phase_r;
          phase_nxt   = PH_DOWN;
          elapsed_nxt = '0;
        end else if (over_click_gap) begin
          phase_nxt   = PH_IDLE;
          prev_nxt    = PH_IDLE;
          elapsed_nxt = '0;
          count_nxt   = '0;
        end
      end
      PH_PRESS: begin
        if (!in_pressed) begin
          prev_nxt    = phase_r;
          phase_nxt   = PH_PRESSEND;
          elapsed_nxt = '0;
        end
      end
      default: begin
        // leaving pressend goes to idle; a bounce keeps the older previous phase
        if (phase_r == PH_PRESSEND && in_pressed && below_debounce)
          prev_nxt = prev_r;
        else
          prev_nxt = phase_r;
        phase_nxt = PH_IDLE;
      end
    endcase
  end

  // result beat
  always_comb begin
    result.click_event = EV_NONE;
    if (phase_r == PH_COUNT && !in_pressed && over_click_gap) begin
      if (count_r == COUNT_W'(1))      result.click_event = EV_SINGLE;
      else if (count_r == COUNT_W'(2)) result.click_event = EV_DOUBLE;
    end
    result.held = (phase_nxt == PH_PRESS);
  end

  // state update per accepted tick
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_IDLE;
      prev_r    <= PH_IDLE;
      elapsed_r <= '0;
      count_r   <= '0;
    end else if (in_beat) begin
      phase_r   <= phase_nxt;
      prev_r    <= prev_nxt;
      elapsed_r <= elapsed_nxt;
      count_r   <= count_nxt;
    end
  end

  // output stage control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (!out_valid_r || out_beat) begin
      out_valid_r  <= skid_valid_r | in_beat;
      skid_valid_r <= 1'b0;
    end else if (in_beat) begin
      skid_valid_r <= 1'b1;
    end
  end

  // output stage payload
  always_ff @(posedge clk) begin
    if (!out_valid_r || out_beat) begin
      out_data_r <= skid_valid_r ? skid_data_r : result;
    end else if (in_beat) begin
      skid_data_r <= result;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_click_event = out_data_r.click_event;
  assign out_held        = out_data_r.held;

  // skid entry only fills behind a waiting result
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid register holds a beat with the result register empty");

  // long-press flag and a click report never share a beat
  a_held_no_event: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_held) |-> (out_click_event == EV_NONE))
    else $error("click reported in the long-press phase");

  // release from long press sets a time mark
  a_press_release_mark: assert property (@(posedge clk) disable iff (!rst_n)
    (in_beat && phase_r == PH_PRESS && !in_pressed) |=>
      (elapsed_r == '0 && phase_r == PH_PRESSEND))
    else $error("long-press release did not restart the timer");

endmodule

// ----- tb/button_click_detector_unit_test.sv -----
// ----------------------------------------------------------------------------
// button_click_detector_unit_test
// Self-checking bench for the button click detector. Button levels are sent
// one tick per beat with bursty valid and a patterned result stall. A local
// model of the phase machine predicts every result beat, and each received
// beat is compared against it. Registers are set over the config port
// between phases and read back.
// ----------------------------------------------------------------------------
module button_click_detector_unit_test;
  import btn_click_pkg::*;

  localparam int unsigned TIMER_BITS     = 16;
  localparam int          HALF_PERIOD    = 2;
  localparam int          RESET_CYCLES   = 8;
  localparam int          RANDOM_TICKS   = 650;
  localparam int          HOLD_CYCLES    = 300;
  localparam int          WATCHDOG_LIMIT = 5000;
  localparam int          LEN_CAP        = 20;

  typedef enum {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_mode_t;

  logic               clk = 1'b0;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic               in_pressed;
  logic               out_valid;
  logic               out_stall;
  logic [1:0]         out_click_event;
  logic               out_held;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  // detector model state and register copies
  phase_t                detector_phase;
  phase_t                detector_last_phase;
  logic [TIMER_BITS-1:0] detector_ticks;
  logic [COUNT_W-1:0]    detector_clicks;
  logic [CFG_W-1:0]      limit_ticks [3];

  result_t predicted_beats[$];
  int      errors      = 0;
  int      ticks_sent  = 0;
  int      burst_left  = 0;
  int      idle_cycles = 0;
  bit      steady      = 1'b0;
  bit      hold_req    = 1'b0;

  button_click_detector_unit #(
    .TIMER_BITS(TIMER_BITS)
  ) u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_pressed     (in_pressed),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_click_event(out_click_event),
    .out_held       (out_held),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  always #HALF_PERIOD clk = ~clk;

  // model: phase change keeps the old phase
  function automatic void enter_phase(phase_t nxt);
    detector_last_phase = detector_phase;
    detector_phase      = nxt;
  endfunction

  function automatic void clear_detector();
    detector_phase      = PH_IDLE;
    detector_last_phase = PH_IDLE;
    detector_ticks      = '0;
    detector_clicks     = '0;
  endfunction

  // model: one tick of the click machine
  task automatic predict_tick(input logic pressed, output result_t res);
    logic [TIMER_BITS-1:0] span;
    logic                  stamp;
    click_event_t          ev;
    ev    = EV_NONE;
    stamp = 1'b0;
    if (detector_ticks != '1) detector_ticks = detector_ticks + 1'b1;
    span = detector_ticks;
    case (detector_phase)
      PH_IDLE: begin
        if (pressed) begin
          enter_phase(PH_DOWN);
          stamp           = 1'b1;
          detector_clicks = '0;
        end
      end
      PH_DOWN: begin
        if (!pressed && span < limit_ticks[REG_DEBOUNCE]) begin
          enter_phase(detector_last_phase);
        end else if (!pressed) begin
          enter_phase(PH_UP);
          stamp = 1'b1;
        end else if (span > limit_ticks[REG_LONG_PRESS]) begin
          enter_phase(PH_PRESS);
        end
      end
      PH_UP: begin
        if (pressed && span < limit_ticks[REG_DEBOUNCE]) begin
          enter_phase(detector_last_phase);
        end else if (span >= limit_ticks[REG_DEBOUNCE]) begin
          if (detector_clicks != COUNT_MAX) detector_clicks = detector_clicks + 1'b1;
          enter_phase(PH_COUNT);
        end
      end
      PH_COUNT: begin
        if (pressed) begin
          enter_phase(PH_DOWN);
          stamp = 1'b1;
        end else if (span > limit_ticks[REG_CLICK_GAP]) begin
          if (detector_clicks == 1) ev = EV_SINGLE;
          else if (detector_clicks == 2) ev = EV_DOUBLE;
          clear_detector();
        end
      end
      PH_PRESS: begin
        if (!pressed) begin
          enter_phase(PH_PRESSEND);
          stamp = 1'b1;
        end
      end
      default: begin
        // release of a long press: a bounce steps back first, then always idle
        if (detector_phase == PH_PRESSEND && pressed && span < limit_ticks[REG_DEBOUNCE])
          enter_phase(detector_last_phase);
        enter_phase(PH_IDLE);
      end
    endcase
    if (stamp) detector_ticks = '0;
    res.click_event = ev;
    res.held        = (detector_phase == PH_PRESS);
  endtask

  // send one tick beat, with random gaps between bursts unless steady
  task automatic send_tick(input logic level);
    result_t res;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 30);
      if (!steady) begin
        @(negedge clk);
        in_valid <= 1'b0;
        repeat ($urandom_range(0, 6)) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    in_valid   <= 1'b1;
    in_pressed <= level;
    do @(posedge clk); while (in_stall);
    predict_tick(level, res);
    predicted_beats.push_back(res);
    ticks_sent++;
  endtask

  task automatic hold_level(input logic level, input int n);
    repeat (n) send_tick(level);
  endtask

  task automatic play_levels(input string levels);
    for (int i = 0; i < levels.len(); i++) send_tick(levels[i] == "1");
  endtask

  // stop sending and let every predicted beat arrive
  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (predicted_beats.size() != 0) @(posedge clk);
  endtask

  // one config transfer: setup cycle, then access cycle
  task automatic reg_access(input logic wr, input reg_index_t idx, input logic [CFG_W-1:0] wdata,
                            output logic [PDATA_W-1:0] rdata);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= PADDR_W'({idx, 2'b00});
    pwdata  <= PDATA_W'(wdata);
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic verify_setting(input reg_index_t idx);
    logic [PDATA_W-1:0] rd;
    reg_access(1'b0, idx, '0, rd);
    if (rd !== PDATA_W'(limit_ticks[idx])) begin
      $display("%0t register %s readback: expected %0d, actual %0d", $time, idx.name(),
               limit_ticks[idx], rd);
      errors++;
    end
  endtask

  task automatic write_setting(input reg_index_t idx, input logic [CFG_W-1:0] value);
    logic [PDATA_W-1:0] rd;
    reg_access(1'b1, idx, value, rd);
    limit_ticks[idx] = value;
    verify_setting(idx);
  endtask

  task automatic apply_limits(input logic [CFG_W-1:0] debounce, input logic [CFG_W-1:0] long_press,
                              input logic [CFG_W-1:0] click_gap);
    wait_drained();
    write_setting(REG_DEBOUNCE, debounce);
    write_setting(REG_LONG_PRESS, long_press);
    write_setting(REG_CLICK_GAP, click_gap);
  endtask

  function automatic int capped(input logic [CFG_W-1:0] v);
    return (v > LEN_CAP) ? LEN_CAP : int'(v);
  endfunction

  // one click sequence shaped around the current limits
  task automatic drive_click_train();
    int clicks, k, dl, ll, gl;
    dl = capped(limit_ticks[REG_DEBOUNCE]);
    ll = capped(limit_ticks[REG_LONG_PRESS]);
    gl = capped(limit_ticks[REG_CLICK_GAP]);
    // now and then a train of 14 to 18 clicks, which can saturate the count
    clicks = ($urandom_range(0, 7) == 0) ? $urandom_range(14, 18) : $urandom_range(1, 4);
    for (k = 0; k < clicks; k++) begin
      if ($urandom_range(0, 7) == 0) hold_level(1'b1, $urandom_range(ll + 2, ll + 5));
      else hold_level(1'b1, $urandom_range((dl > 0) ? dl : 1, dl + 2));
      // bounce right after release
      if ($urandom_range(0, 5) == 0) begin
        hold_level(1'b0, 1);
        hold_level(1'b1, $urandom_range(1, 2));
      end
      if (k == clicks - 1) hold_level(1'b0, dl + gl + $urandom_range(2, 5));
      else hold_level(1'b0, $urandom_range(dl + 1, ((gl > dl) ? gl : dl) + 1));
    end
  endtask

  task automatic drive_noise();
    repeat ($urandom_range(1, 8)) send_tick(1'($urandom_range(0, 1)));
  endtask

  task automatic test_register_defaults();
    verify_setting(REG_DEBOUNCE);
    verify_setting(REG_LONG_PRESS);
    verify_setting(REG_CLICK_GAP);
  endtask

  task automatic test_click_patterns();
    apply_limits(16'd2, 16'd2, 16'd1);
    play_levels("110000");      // single click
    play_levels("11000110000"); // double click
    play_levels("10");          // bounce in down, back to idle
    play_levels("110110010");   // bounce in up, then up phase left while pressed
    play_levels("111101");      // long press, bounce on release, then idle
    apply_limits(16'd0, 16'd0, 16'd0);
    play_levels("1101001");
    hold_level(1'b0, 3);
  endtask

  task automatic test_random_trains();
    int start, setting_no;
    start      = ticks_sent;
    setting_no = 0;
    while (ticks_sent - start < RANDOM_TICKS) begin
      case (setting_no % 4)
        1:       apply_limits(16'd0, 16'd0, 16'd0);
        2:       apply_limits(16'd1, 16'hFFFF, 16'hFFFF);
        default: apply_limits($urandom_range(0, 5), $urandom_range(0, 12), $urandom_range(0, 8));
      endcase
      // some phases run without any idling on either side
      steady = (setting_no % 3 == 2);
      repeat (6) begin
        if ($urandom_range(0, 4) == 0) drive_noise();
        else drive_click_train();
      end
      setting_no++;
    end
    steady = 1'b0;
  endtask

  // receiver holds off while ticks keep coming, so the input side backs up
  task automatic test_backpressure();
    apply_limits(16'd2, 16'd6, 16'd3);
    hold_req = 1'b1;
    repeat (3) drive_click_train();
  endtask

  // result stall patterns and the long hold-off
  initial begin : receiver
    stall_mode_t mode;
    int          left;
    out_stall = 1'b0;
    mode      = STALL_NONE;
    left      = 0;
    forever begin
      @(negedge clk);
      if (left == 0) begin
        mode = stall_mode_t'($urandom_range(0, 3));
        left = $urandom_range(20, 80);
      end
      left--;
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
        out_stall <= 1'b0;
      end else if (steady) begin
        out_stall <= 1'b0;
      end else begin
        case (mode)
          STALL_NONE:  out_stall <= 1'b0;
          STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
          STALL_HEAVY: out_stall <= ($urandom_range(0, 9) < 6);
          default:     out_stall <= (left % 3 == 0);
        endcase
      end
    end
  end

  // compare each result beat against the oldest prediction
  always @(posedge clk) begin : result_check
    result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (predicted_beats.size() == 0) begin
        $display("%0t unexpected result beat: expected none, actual event %0d held %0b",
                 $time, out_click_event, out_held);
        errors++;
      end else begin
        want = predicted_beats.pop_front();
        if (out_click_event !== want.click_event) begin
          $display("%0t click_event mismatch: expected %0d, actual %0d", $time,
                   want.click_event, out_click_event);
          errors++;
        end
        if (out_held !== want.held) begin
          $display("%0t held mismatch: expected %0b, actual %0b", $time, want.held, out_held);
          errors++;
        end
      end
    end
  end

  // watchdog on cycles without any accepted beat
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("%0t watchdog: no beat accepted for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin : stimulus
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_pressed = 1'b0;
    psel       = 1'b0;
    penable    = 1'b0;
    pwrite     = 1'b0;
    paddr      = '0;
    pwdata     = '0;
    limit_ticks[REG_DEBOUNCE]   = DEBOUNCE_RST;
    limit_ticks[REG_LONG_PRESS] = LONG_PRESS_RST;
    limit_ticks[REG_CLICK_GAP]  = CLICK_GAP_RST;
    clear_detector();
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;

    test_register_defaults();
    test_click_patterns();
    test_random_trains();
    test_backpressure();

    wait_drained();
    repeat (8) @(posedge clk);
    if (errors == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule
